### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is asserted
`define CBZ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cbz check failed");
// clocked check that also runs during reset
`define CBZ_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("cbz check failed");
`else
`define CBZ_ASSERT(label, clk, rst_n, prop)
`define CBZ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/cbz_pkg.sv
// shared types and constants of the cubic bezier point sampler
package cbz_pkg;

	// field widths
	localparam int COORD_WIDTH    = 16;
	localparam int COUNT_WIDTH    = 7;
	localparam int INDEX_WIDTH    = 6;
	localparam int MAX_POINTS_DEF = 64;

	// curve parameter t in 0 .. 2^T_FRAC_BITS inclusive
	localparam int T_FRAC_BITS = 16;
	localparam int T_WIDTH     = T_FRAC_BITS + 1;
	localparam int T2_WIDTH    = 2 * T_WIDTH;

	// bernstein weights scaled by 2^(3*T_FRAC_BITS), at most 2^(3*T_FRAC_BITS)
	localparam int WEIGHT_WIDTH = 3 * T_FRAC_BITS + 1;
	localparam int W_LO_WIDTH   = WEIGHT_WIDTH / 2;
	localparam int W_HI_WIDTH   = WEIGHT_WIDTH - W_LO_WIDTH;

	// exact weighted sum and its rounded form
	localparam int ACC_WIDTH   = COORD_WIDTH + WEIGHT_WIDTH + 2;
	localparam int ROUND_SHIFT = 3 * T_FRAC_BITS;
	localparam int RND_WIDTH   = ACC_WIDTH - ROUND_SHIFT;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [3:0]                  coord_vec_t;
	typedef logic [T_WIDTH-1:0]            t_val_t;
	typedef logic [WEIGHT_WIDTH-1:0]       weight_t;
	typedef weight_t [3:0]                 weights_t;
	typedef logic signed [ACC_WIDTH-1:0]   acc_t;

	localparam t_val_t T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam acc_t ROUND_HALF =
		{{(ACC_WIDTH - ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT - 1){1'b0}}};

	// four control points, one vector per axis
	typedef struct packed {
		coord_vec_t x;
		coord_vec_t y;
	} ctrl_pts_t;

	// sample bookkeeping that travels with each point
	typedef struct packed {
		logic [INDEX_WIDTH-1:0] index;
		logic                   last;
	} point_tag_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_EMIT
	} seq_state_t;

endpackage

### rtl/cbz_in_if.sv
// input channel: control points and sample count
interface cbz_in_if import cbz_pkg::*; ();
	logic                   valid;
	logic                   ready;
	coord_t                 p0_x;
	coord_t                 p0_y;
	coord_t                 p1_x;
	coord_t                 p1_y;
	coord_t                 p2_x;
	coord_t                 p2_y;
	coord_t                 p3_x;
	coord_t                 p3_y;
	logic [COUNT_WIDTH-1:0] point_count;

	modport source (
		output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
		input  ready
	);
	modport sink (
		input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count,
		output ready
	);
endinterface

### rtl/cbz_out_if.sv
// output channel: one sampled curve point
interface cbz_out_if import cbz_pkg::*; ();
	logic                   valid;
	logic                   ready;
	coord_t                 point_x;
	coord_t                 point_y;
	logic [INDEX_WIDTH-1:0] point_index;
	logic                   last_point;

	modport source (
		output valid, point_x, point_y, point_index, last_point,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_index, last_point,
		output ready
	);
endinterface

### rtl/cubic_bezier_point_sampler_unit.sv
// top level of the cubic bezier point sampler
// Takes one transfer of four control points and a count N (clamped to 2 .. MAX_POINTS)
// and returns N curve samples at t = i/(N-1), rounded and saturated Q12.4, the last
// one flagged. An item occupies the front end while it is captured, while the bit-serial
// reciprocal of N-1 is formed (one quotient bit per cycle), and while its samples are
// issued, one sample per cycle unless the output stalls; the next item is taken once its
// last sample has been issued. Samples come out of an eight-stage pipeline plus an output
// register. Back-pressure on the output stalls the whole pipeline without losing or
// repeating a sample.
`include "assert_macros.svh"

module cubic_bezier_point_sampler_unit import cbz_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cbz_in_if.sink    in_ch,
	cbz_out_if.source out_ch
);

	logic       en;

	logic       valid_s1, valid_s3;
	t_val_t     t_s1;
	ctrl_pts_t  pts_s1, pts_s3;
	point_tag_t tag_s1, tag_s3;
	weights_t   w_s3;

	logic       vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	point_tag_t tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	coord_t     x_s8, y_s8;

	logic                   out_valid_q;
	coord_t                 out_x_q, out_y_q;
	logic [INDEX_WIDTH-1:0] out_index_q;
	logic                   out_last_q;

	// pipeline advances when the output slot is free or being taken
	assign en = !out_valid_q || out_ch.ready;

	cbz_seq #(
		.MAX_POINTS (MAX_POINTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.en       (en),
		.valid_s1 (valid_s1),
		.t_s1     (t_s1),
		.pts_s1   (pts_s1),
		.tag_s1   (tag_s1)
	);

	cbz_weights u_weights (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.t_s1     (t_s1),
		.pts_s1   (pts_s1),
		.tag_s1   (tag_s1),
		.valid_s3 (valid_s3),
		.w_s3     (w_s3),
		.pts_s3   (pts_s3),
		.tag_s3   (tag_s3)
	);

	cbz_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.coords (pts_s3.x),
		.w_s3   (w_s3),
		.point  (x_s8)
	);

	cbz_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.coords (pts_s3.y),
		.w_s3   (w_s3),
		.point  (y_s8)
	);

	// valid line alongside the axis pipelines, and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s4      <= valid_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			vld_s8      <= vld_s7;
			out_valid_q <= vld_s8;
		end
	end

	// tag line and output register
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			if (vld_s8) begin
				out_x_q     <= x_s8;
				out_y_q     <= y_s8;
				out_index_q <= tag_s8.index;
				out_last_q  <= tag_s8.last;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.point_x     = out_x_q;
	assign out_ch.point_y     = out_y_q;
	assign out_ch.point_index = out_index_q;
	assign out_ch.last_point  = out_last_q;

	// a stalled pipeline keeps its final stage
	`CBZ_ASSERT(a_stall_holds, clk, arst_n, !en |=> $stable(vld_s8))
	// the stepped t lands exactly on one at the last sample
	`CBZ_ASSERT(a_last_t_one, clk, arst_n, valid_s1 && tag_s1.last |-> t_s1 == T_ONE)
	// an accepted item keeps the input closed in the next cycle
	`CBZ_ASSERT(a_busy_after_take, clk, arst_n, in_ch.valid && in_ch.ready |=> !in_ch.ready)

endmodule

### rtl/cbz_seq.sv
// point sequencer: count clamp, serial reciprocal of N-1 and t stepping
module cbz_seq import cbz_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cbz_in_if.sink     in_ch,
	input  logic       en,
	output logic       valid_s1,
	output t_val_t     t_s1,
	output ctrl_pts_t  pts_s1,
	output point_tag_t tag_s1
);

	localparam int NW        = $clog2(MAX_POINTS);
	localparam int DIV_STEPS = T_WIDTH;
	localparam int SW        = $clog2(DIV_STEPS);

	seq_state_t     state_q, state_d;
	logic [SW-1:0]  step_q;
	logic [NW-1:0]  den_q, rem_q, idx_q, r_q;
	t_val_t         quo_q, t_q;
	ctrl_pts_t      pts_q;

	logic [NW-1:0]  den_in;
	logic [NW:0]    rem_sh, r_sum;
	logic           rem_ge, r_wrap;
	logic [NW-1:0]  rem_nx, r_nx;
	t_val_t         t_nx;
	logic           div_last, emit_last, accept, issue;

	// clamp the count to 2 .. MAX_POINTS and keep N-1
	always_comb begin
		if (in_ch.point_count < COUNT_WIDTH'(2)) begin
			den_in = NW'(1);
		end else if (32'(in_ch.point_count) > MAX_POINTS) begin
			den_in = NW'(MAX_POINTS - 1);
		end else begin
			den_in = NW'(32'(in_ch.point_count) - 32'd1);
		end
	end

	// restoring division of 2^T_FRAC_BITS by N-1, one quotient bit per cycle
	assign rem_sh   = {rem_q, (step_q == '0)};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign rem_nx   = rem_ge ? NW'(rem_sh - {1'b0, den_q}) : rem_sh[NW-1:0];
	assign div_last = step_q == SW'(DIV_STEPS - 1);

	// t steps by quotient plus carry of the remainder
	assign r_sum     = {1'b0, r_q} + {1'b0, rem_q};
	assign r_wrap    = r_sum >= {1'b0, den_q};
	assign r_nx      = r_wrap ? NW'(r_sum - {1'b0, den_q}) : r_sum[NW-1:0];
	assign t_nx      = t_q + quo_q + T_WIDTH'(r_wrap);
	assign emit_last = idx_q == den_q;

	assign accept = in_ch.valid && in_ch.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		issue       = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = SEQ_DIV;
			end
			SEQ_DIV: begin
				if (div_last) state_d = SEQ_EMIT;
			end
			SEQ_EMIT: begin
				issue = en;
				if (en && emit_last) state_d = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// counters and stage-one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= '0;
			end else if (state_q == SEQ_DIV) begin
				step_q <= step_q + SW'(1);
			end
			if (state_q == SEQ_DIV) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + NW'(1);
			end
			if (en) valid_s1 <= issue;
		end
	end

	// item capture, divider and stepping datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			pts_q.x <= {in_ch.p3_x, in_ch.p2_x, in_ch.p1_x, in_ch.p0_x};
			pts_q.y <= {in_ch.p3_y, in_ch.p2_y, in_ch.p1_y, in_ch.p0_y};
			den_q   <= den_in;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (state_q == SEQ_DIV) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[T_WIDTH-2:0], rem_ge};
			if (div_last) begin
				t_q <= '0;
				r_q <= den_q >> 1;
			end
		end else if (issue) begin
			t_q <= t_nx;
			r_q <= r_nx;
		end
		if (issue) begin
			t_s1         <= t_q;
			pts_s1       <= pts_q;
			tag_s1.index <= INDEX_WIDTH'(idx_q);
			tag_s1.last  <= emit_last;
		end
	end

endmodule

### rtl/cbz_weights.sv
// bernstein weight pipeline: powers of t and 1-t over two stages
module cbz_weights import cbz_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_s1,
	input  t_val_t     t_s1,
	input  ctrl_pts_t  pts_s1,
	input  point_tag_t tag_s1,
	output logic       valid_s3,
	output weights_t   w_s3,
	output ctrl_pts_t  pts_s3,
	output point_tag_t tag_s3
);

	t_val_t                     mt_s1;
	logic [T_WIDTH+1:0]         t3_s1;

	logic                       valid_s2;
	t_val_t                     t_s2, mt_s2;
	logic [T2_WIDTH-1:0]        t2_s2, mt2_s2;
	logic [T2_WIDTH+1:0]        tmt3_s2;
	ctrl_pts_t                  pts_s2;
	point_tag_t                 tag_s2;

	logic [T2_WIDTH+T_WIDTH-1:0]   w0_full, w3_full;
	logic [T2_WIDTH+T_WIDTH+1:0]   w1_full, w2_full;

	// 1-t and 3t
	assign mt_s1 = T_ONE - t_s1;
	assign t3_s1 = (T_WIDTH + 2)'(t_s1) + ((T_WIDTH + 2)'(t_s1) << 1);

	// third-order products
	assign w0_full = mt2_s2 * mt_s2;
	assign w1_full = tmt3_s2 * mt_s2;
	assign w2_full = tmt3_s2 * t_s2;
	assign w3_full = t2_s2 * t_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// second-order products, then weights
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_s1;
			mt_s2   <= mt_s1;
			t2_s2   <= t_s1 * t_s1;
			mt2_s2  <= mt_s1 * mt_s1;
			tmt3_s2 <= t3_s1 * mt_s1;
			pts_s2  <= pts_s1;
			tag_s2  <= tag_s1;

			w_s3[0] <= w0_full[WEIGHT_WIDTH-1:0];
			w_s3[1] <= w1_full[WEIGHT_WIDTH-1:0];
			w_s3[2] <= w2_full[WEIGHT_WIDTH-1:0];
			w_s3[3] <= w3_full[WEIGHT_WIDTH-1:0];
			pts_s3  <= pts_s2;
			tag_s3  <= tag_s2;
		end
	end

endmodule

### rtl/cbz_axis.sv
// one axis: weighted sum of control coordinates, rounding and saturation
module cbz_axis import cbz_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  coord_vec_t coords,
	input  weights_t   w_s3,
	output coord_t     point
);

	localparam int LO_PW = COORD_WIDTH + W_LO_WIDTH + 1;
	localparam int HI_PW = COORD_WIDTH + W_HI_WIDTH + 1;
	localparam logic signed [RND_WIDTH-1:0] RND_MAX = RND_WIDTH'((2 ** (COORD_WIDTH - 1)) - 1);
	localparam logic signed [RND_WIDTH-1:0] RND_MIN = RND_WIDTH'(-(2 ** (COORD_WIDTH - 1)));

	logic signed [LO_PW-1:0]     lo_s4 [4];
	logic signed [HI_PW-1:0]     hi_s4 [4];
	acc_t                        term_s5 [4];
	acc_t                        pair_s6 [2];
	acc_t                        total_s7;
	logic signed [RND_WIDTH-1:0] rnd_s8;

	logic                        neg;
	acc_t                        rsum;

	// round half away from zero: floor((x + half - sign) / 2^shift)
	assign neg  = total_s7[ACC_WIDTH-1];
	assign rsum = total_s7 + ROUND_HALF - {{(ACC_WIDTH - 1){1'b0}}, neg};

	// split products, recombine, add tree, round
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				lo_s4[k] <= $signed(coords[k]) *
					$signed({1'b0, w_s3[k][W_LO_WIDTH-1:0]});
				hi_s4[k] <= $signed(coords[k]) *
					$signed({1'b0, w_s3[k][WEIGHT_WIDTH-1:W_LO_WIDTH]});
				term_s5[k] <= (acc_t'(hi_s4[k]) <<< W_LO_WIDTH) + acc_t'(lo_s4[k]);
			end
			pair_s6[0] <= term_s5[0] + term_s5[1];
			pair_s6[1] <= term_s5[2] + term_s5[3];
			total_s7   <= pair_s6[0] + pair_s6[1];
			rnd_s8     <= rsum[ACC_WIDTH-1:ROUND_SHIFT];
		end
	end

	// saturate to the coordinate range
	always_comb begin
		if (rnd_s8 > RND_MAX) begin
			point = RND_MAX[COORD_WIDTH-1:0];
		end else if (rnd_s8 < RND_MIN) begin
			point = RND_MIN[COORD_WIDTH-1:0];
		end else begin
			point = rnd_s8[COORD_WIDTH-1:0];
		end
	end

endmodule

### verif/cubic_bezier_point_sampler_unit_tb.sv
// testbench for the cubic bezier point sampler: curve requests in, checked samples out
module cubic_bezier_point_sampler_unit_tb import cbz_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam coord_t COORD_MIN   = 16'sh8000;
	localparam coord_t COORD_MAX   = 16'sh7fff;
	localparam int     STALL_LIMIT = 3000;
	localparam int     LONG_HOLD   = 400;
	localparam int     TAIL_CYCLES = 40;
	localparam int     RANDOM_REQS = 200;
	localparam int     REPORT_CAP  = 100;

	// one curve request as it crosses the input channel
	typedef struct packed {
		coord_t                 p0_x;
		coord_t                 p0_y;
		coord_t                 p1_x;
		coord_t                 p1_y;
		coord_t                 p2_x;
		coord_t                 p2_y;
		coord_t                 p3_x;
		coord_t                 p3_y;
		logic [COUNT_WIDTH-1:0] point_count;
	} curve_req_t;

	// one sampled point as it crosses the output channel
	typedef struct packed {
		coord_t                 x;
		coord_t                 y;
		logic [INDEX_WIDTH-1:0] index;
		logic                   last;
	} curve_point_t;

	logic clk;
	logic arst_n;

	cbz_in_if  in_ch ();
	cbz_out_if out_ch ();

	curve_point_t pending_points[$];
	int           errors;
	int           quiet_cycles;
	int           hold_req;
	bit           src_steady;
	bit           sink_steady;

	cubic_bezier_point_sampler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one axis of the bernstein sum, exact, then rounded half away from zero and saturated
	function automatic coord_t bezier_axis(input coord_t c0, c1, c2, c3, input t_val_t t, mt);
		logic signed [79:0] a0, a1, a2, a3, ts, ms, sum;
		logic [79:0]        mag, rounded;
		logic               neg;
		coord_t             res;
		a0 = c0;
		a1 = c1;
		a2 = c2;
		a3 = c3;
		ts = t;
		ms = mt;
		sum = a0 * ms * ms * ms + 80'sd3 * a1 * ms * ms * ts
			+ 80'sd3 * a2 * ms * ts * ts + a3 * ts * ts * ts;
		neg = sum < 0;
		mag = neg ? -sum : sum;
		rounded = (mag + (80'd1 << (3 * T_FRAC_BITS - 1))) >> (3 * T_FRAC_BITS);
		if (neg) begin
			if (rounded > (80'd1 << (COORD_WIDTH - 1)))
				rounded = 80'd1 << (COORD_WIDTH - 1);
		end else if (rounded > (80'd1 << (COORD_WIDTH - 1)) - 1) begin
			rounded = (80'd1 << (COORD_WIDTH - 1)) - 1;
		end
		res = rounded[COORD_WIDTH-1:0];
		if (neg)
			res = -res;
		return res;
	endfunction

	// queue every sample that an accepted request must produce
	function automatic void predict_samples(input curve_req_t r);
		int unsigned  n, den, i, t_raw;
		curve_point_t s;
		n = r.point_count;
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS_DEF)
			n = MAX_POINTS_DEF;
		den = n - 1;
		for (i = 0; i < n; i++) begin
			t_raw = ((i << T_FRAC_BITS) + den / 2) / den;
			s.x = bezier_axis(r.p0_x, r.p1_x, r.p2_x, r.p3_x, t_val_t'(t_raw),
				T_ONE - t_val_t'(t_raw));
			s.y = bezier_axis(r.p0_y, r.p1_y, r.p2_y, r.p3_y, t_val_t'(t_raw),
				T_ONE - t_val_t'(t_raw));
			s.index = i[INDEX_WIDTH-1:0];
			s.last = (i == den);
			pending_points = {pending_points, s};
		end
	endfunction

	function automatic curve_req_t make_curve(input coord_t p0x, p0y, p1x, p1y, p2x, p2y,
		p3x, p3y, input int count);
		curve_req_t r;
		r.p0_x = p0x;
		r.p0_y = p0y;
		r.p1_x = p1x;
		r.p1_y = p1y;
		r.p2_x = p2x;
		r.p2_y = p2y;
		r.p3_x = p3x;
		r.p3_y = p3y;
		r.point_count = count[COUNT_WIDTH-1:0];
		return r;
	endfunction

	// mostly full-range values, with extremes and tiny values mixed in
	function automatic coord_t rand_coord();
		coord_t c;
		case ($urandom_range(0, 7))
			0: c = COORD_MIN;
			1: c = COORD_MAX;
			2: c = coord_t'($urandom_range(0, 31)) - coord_t'(16);
			default: c = coord_t'($urandom);
		endcase
		return c;
	endfunction

	function automatic curve_req_t rand_curve(input int count);
		return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), count);
	endfunction

	// mostly short runs, now and then any count the field allows
	function automatic int rand_count();
		return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 16) : $urandom_range(0, 127);
	endfunction

	// offer one request and wait for its transfer; valid stays high afterwards
	task automatic send_curve(input curve_req_t r);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.p0_x        <= r.p0_x;
		in_ch.p0_y        <= r.p0_y;
		in_ch.p1_x        <= r.p1_x;
		in_ch.p1_y        <= r.p1_y;
		in_ch.p2_x        <= r.p2_x;
		in_ch.p2_y        <= r.p2_y;
		in_ch.p3_x        <= r.p3_x;
		in_ch.p3_y        <= r.p3_y;
		in_ch.point_count <= r.point_count;
		do @(posedge clk); while (!in_ch.ready);
		predict_samples(r);
	endtask

	task automatic release_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		release_input();
		while (pending_points.size() != 0) @(posedge clk);
	endtask

	// counts below two, at the edges of the range and above the maximum
	task automatic test_count_clamping();
		int counts[7];
		int k;
		counts = '{0, 1, 2, 3, MAX_POINTS_DEF, MAX_POINTS_DEF + 1, 127};
		for (k = 0; k < 7; k++)
			send_curve(rand_curve(counts[k]));
		wait_drained();
	endtask

	// extreme coordinates, mixed signs and exact half-lsb ties
	task automatic test_coordinate_extremes();
		send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 5));
		send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 5));
		send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, MAX_POINTS_DEF));
		send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 17));
		send_curve(make_curve('0, '0, '0, '0, '0, '0, '0, '0, 2));
		send_curve(make_curve(16'sd4, -16'sd4, '0, '0, '0, '0, '0, '0, 3));
		send_curve(make_curve('0, '0, '0, '0, '0, '0, -16'sd4, 16'sd4, 3));
		send_curve(make_curve(16'sd1, -16'sd1, -16'sd1, 16'sd1,
			16'sd1, -16'sd1, -16'sd1, 16'sd1, 9));
		wait_drained();
	endtask

	// receiver holds off while full-length requests keep coming, then the sender waits
	task automatic test_back_pressure();
		int k;
		hold_req = LONG_HOLD;
		src_steady = 1'b1;
		for (k = 0; k < 6; k++)
			send_curve(rand_curve(MAX_POINTS_DEF));
		src_steady = 1'b0;
		wait_drained();
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		int k;
		src_steady = 1'b1;
		sink_steady = 1'b1;
		for (k = 0; k < 10; k++)
			send_curve(rand_curve(rand_count()));
		src_steady = 1'b0;
		sink_steady = 1'b0;
		release_input();
	endtask

	// random requests, with stretches that run without idling
	task automatic test_random_curves();
		int k;
		for (k = 0; k < RANDOM_REQS; k++) begin
			if (k % 40 == 0) begin
				src_steady = ($urandom_range(0, 3) == 0);
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			send_curve(rand_curve(rand_count()));
		end
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// receiver: a random wait before each transfer, plus long hold-offs on request
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end
			gap = sink_steady ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && hold_req == 0);
		end
	end

	// compare every output transfer with the oldest expected sample
	always @(posedge clk) begin
		curve_point_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.point_x, out_ch.point_y, out_ch.point_index, out_ch.last_point};
			if (pending_points.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected point expected none actual x=%0d y=%0d index=%0d last=%0b",
						$time, got.x, got.y, got.index, got.last);
			end else begin
				want = pending_points.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.index !== want.index
					|| got.last !== want.last) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: point mismatch expected x=%0d y=%0d index=%0d last=%0b actual x=%0d y=%0d index=%0d last=%0b",
							$time, want.x, want.y, want.index, want.last,
							got.x, got.y, got.index, got.last);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		errors = 0;
		hold_req = 0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		quiet_cycles <= 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.p0_x <= '0;
		in_ch.p0_y <= '0;
		in_ch.p1_x <= '0;
		in_ch.p1_y <= '0;
		in_ch.p2_x <= '0;
		in_ch.p2_y <= '0;
		in_ch.p3_x <= '0;
		in_ch.p3_y <= '0;
		in_ch.point_count <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_count_clamping();
		test_coordinate_extremes();
		test_back_pressure();
		test_back_to_back();
		test_random_curves();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/cbz_pkg.sv
rtl/cbz_in_if.sv
rtl/cbz_out_if.sv
rtl/cbz_seq.sv
rtl/cbz_weights.sv
rtl/cbz_axis.sv
rtl/cubic_bezier_point_sampler_unit.sv
verif/cubic_bezier_point_sampler_unit_tb.sv
